// ===== rtl/acbc_pkg.sv =====
// shared types, constants and functions for the aes cbc block cipher
`default_nettype none
package acbc_pkg;

	localparam int MaxRoundsDef = 14;
	localparam int MaxRoundsLo  = 10;
	localparam logic [7:0] RconInit = 8'h01;
	localparam logic [7:0] GfPoly   = 8'h1b;

	localparam logic [2:0] RegKeySize = 3'd0;
	localparam logic [2:0] RegKey0    = 3'd1;
	localparam logic [2:0] RegKey1    = 3'd2;
	localparam logic [2:0] RegKey2    = 3'd3;
	localparam logic [2:0] RegKey3    = 3'd4;
	localparam logic [2:0] RegIvHigh  = 3'd5;
	localparam logic [2:0] RegIvLow   = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_ROUND,
		ST_LOAD,
		ST_FINAL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} kx_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// byte 0 sits in bits 127:120
	function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
		logic [7:0] t [16];
		logic [7:0] b [16];
		logic [127:0] o;
		for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inv) t[((c+r)%4)*4+r] = INV_SBOX[b[c*4+r]];
				else t[c*4+r] = SBOX[b[((c+r)%4)*4+r]];
			end
		end
		for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
		sub_shift = o;
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
		logic [7:0] a0, a1, a2, a3, t, u, v;
		logic [127:0] o;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			if (inv) begin
				u = xt(xt(a0 ^ a2));
				v = xt(xt(a1 ^ a3));
				a0 ^= u; a1 ^= v; a2 ^= u; a3 ^= v;
			end
			t = a0 ^ a1 ^ a2 ^ a3;
			o[127-32*c -: 32] = {a0 ^ t ^ xt(a0 ^ a1), a1 ^ t ^ xt(a1 ^ a2),
				a2 ^ t ^ xt(a2 ^ a3), a3 ^ t ^ xt(a3 ^ a0)};
		end
		mix = o;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/acbc_key_exp.sv =====
// key expansion engine writing one round key word per cycle into the key memory
`default_nettype none
module acbc_key_exp import acbc_pkg::*; #(
	parameter int MAX_ROUNDS = MaxRoundsDef,
	localparam int RkWords = 4 * (MAX_ROUNDS + 1),
	localparam int AW = $clog2(RkWords)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire kx_ctl_t       ctl,
	input  wire logic [1:0]    ks,
	input  wire logic [255:0]  key,
	output logic               done,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output logic [31:0]        wdata
);
	// the last nk words are kept in a window so the memory needs no read port here
	logic [31:0]   win_q [8];
	logic [AW:0]   idx_q;
	logic          run_q;
	logic [7:0]    rcon_q;
	logic [2:0]    pos_q;
	logic [3:0]    nk;
	logic [AW:0]   total;
	logic [31:0]   t, nw, prev, back;

	always_comb begin
		unique case (ks)
			2'd0: nk = 4'd4;
			2'd1: nk = 4'd6;
			default: nk = 4'd8;
		endcase
		total = (AW+1)'(4) * ((AW+1)'(nk) + (AW+1)'(7));
		if (total > (AW+1)'(RkWords)) total = (AW+1)'(RkWords);
		prev = win_q[0];
		back = win_q[3'(nk - 4'd1)];
		t = prev;
		if (pos_q == 3'd0)
			t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'h0};
		else if (nk > 4'd6 && pos_q == 3'd4)
			t = sub_word(prev);
		if (idx_q < (AW+1)'(nk))
			nw = key[255 - 32*idx_q[2:0] -: 32];
		else
			nw = back ^ t;
	end

	assign we    = run_q;
	assign waddr = idx_q[AW-1:0];
	assign wdata = nw;
	assign done  = run_q && (idx_q + 1'b1 == total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			idx_q  <= '0;
			rcon_q <= RconInit;
			pos_q  <= '0;
		end else if (ctl.start && !ctl.busy) begin
			run_q  <= 1'b1;
			idx_q  <= '0;
			rcon_q <= RconInit;
			pos_q  <= '0;
		end else if (run_q) begin
			idx_q <= idx_q + 1'b1;
			if (done) run_q <= 1'b0;
			if (idx_q >= (AW+1)'(nk)) begin
				if (pos_q == 3'd0) rcon_q <= xt(rcon_q);
			end
			if (idx_q + 1'b1 >= (AW+1)'(nk))
				pos_q <= (pos_q == 3'(nk - 4'd1) || idx_q + 1'b1 == (AW+1)'(nk)) ? 3'd0
					: pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			win_q[0] <= nw;
			for (int i = 1; i < 8; i++) win_q[i] <= win_q[i-1];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/acbc_round.sv =====
// round datapath: key memory, one round per cycle over a 128-bit state register
`default_nettype none
module acbc_round import acbc_pkg::*; #(
	parameter int MAX_ROUNDS = MaxRoundsDef,
	localparam int RkWords = 4 * (MAX_ROUNDS + 1),
	localparam int AW = $clog2(RkWords),
	localparam int RW = $clog2(MAX_ROUNDS + 1)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic [RW-1:0] rd_round,
	input  wire logic          load,
	input  wire logic          step,
	input  wire logic          last,
	input  wire logic          dec,
	input  wire logic [127:0]  din,
	output logic [127:0]       state
);
	// four word banks so all four words of one round key are read together
	localparam int BD = MAX_ROUNDS + 1;
	logic [31:0]  bank0 [BD];
	logic [31:0]  bank1 [BD];
	logic [31:0]  bank2 [BD];
	logic [31:0]  bank3 [BD];
	logic [127:0] rk_q;
	logic [127:0] state_q;
	logic [127:0] ss, nx;
	logic [RW-1:0] wrow;

	assign wrow = RW'(waddr >> 2);

	always_ff @(posedge clk) begin
		if (we) begin
			unique case (waddr[1:0])
				2'd0: bank0[wrow] <= wdata;
				2'd1: bank1[wrow] <= wdata;
				2'd2: bank2[wrow] <= wdata;
				default: bank3[wrow] <= wdata;
			endcase
		end
		rk_q <= {bank0[rd_round], bank1[rd_round], bank2[rd_round], bank3[rd_round]};
	end

	always_comb begin
		ss = sub_shift(state_q, dec);
		if (last) nx = ss ^ rk_q;
		else if (dec) nx = mix(ss ^ rk_q, 1'b1);
		else nx = mix(ss, 1'b0) ^ rk_q;
	end

	always_ff @(posedge clk) begin
		if (load) state_q <= din ^ rk_q;
		else if (step) state_q <= nx;
	end

	assign state = state_q;
endmodule
`default_nettype wire

// ===== rtl/aes_cbc_block_cipher.sv =====
// aes cbc block cipher top level: registers, chaining and round sequencer
// per item: key expansion, one key read, one load, nr rounds and one result step
// (nr = 10, 12 or 14); a new item is taken only after the result register has taken
// the last one; the result step waits only while an older result stalls
// reset clears control, the chain and the registers (key size to 256 bits)
`default_nettype none
module aes_cbc_block_cipher import acbc_pkg::*; #(
	parameter int MAX_ROUNDS = MaxRoundsDef,
	localparam int RW = $clog2(MAX_ROUNDS + 1),
	localparam int AW = $clog2(4 * (MAX_ROUNDS + 1))
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        cmd,
	input  wire logic        restart,
	input  wire logic [63:0] data_high,
	input  wire logic [63:0] data_low,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      result_high,
	output logic [63:0]      result_low
);
	logic [1:0]   key_size_q;
	logic [255:0] key_q;
	logic [127:0] iv_q, chain_q, blk_q, res_q;
	logic         dec_q, rvalid_q;
	state_t       st_q, st_d;
	logic [RW-1:0] rnd_q, rnd_d;
	logic [3:0]   nr;
	logic         accept, kdone, kwe, load, step, last, out_load;
	logic [AW-1:0] kaddr;
	logic [31:0]  kdata;
	logic [127:0] rstate, chain_use;
	kx_ctl_t      kctl;

	always_comb begin
		unique case (key_size_q)
			2'd0: nr = 4'd10;
			2'd1: nr = 4'd12;
			default: nr = 4'd14;
		endcase
	end

	assign in_stall = (st_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign kctl     = '{start: accept, busy: 1'b0};
	// the result register takes a new item unless it still holds an older one that is stalled
	assign out_load = (st_q == ST_OUT) && !(rvalid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= 2'd2;
			key_q      <= '0;
			iv_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegKeySize: key_size_q <= cfg_data[1:0];
				RegKey0:    key_q[255:192] <= cfg_data;
				RegKey1:    key_q[191:128] <= cfg_data;
				RegKey2:    key_q[127:64]  <= cfg_data;
				RegKey3:    key_q[63:0]    <= cfg_data;
				RegIvHigh:  iv_q[127:64]   <= cfg_data;
				RegIvLow:   iv_q[63:0]     <= cfg_data;
				default: ;
			endcase
		end
	end

	acbc_key_exp #(.MAX_ROUNDS(MAX_ROUNDS)) u_kx (
		.clk, .arst_n, .ctl(kctl), .ks(key_size_q), .key(key_q),
		.done(kdone), .we(kwe), .waddr(kaddr), .wdata(kdata)
	);

	// encrypt walks keys 0..nr, decrypt nr..0; the key memory is addressed
	// with the next round so its registered output lines up with rnd_q
	always_comb begin
		st_d  = st_q;
		rnd_d = rnd_q;
		load  = 1'b0;
		step  = 1'b0;
		last  = 1'b0;
		unique case (st_q)
			ST_IDLE: if (accept) st_d = ST_EXPAND;
			ST_EXPAND: if (kdone) begin
				st_d  = ST_ROUND;
				rnd_d = dec_q ? RW'(nr) : '0;
			end
			// the last key word was just written, read the first round key now
			ST_ROUND: st_d = ST_LOAD;
			ST_LOAD: begin
				load  = 1'b1;
				rnd_d = dec_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
				st_d  = ST_FINAL;
			end
			ST_FINAL: begin
				step = 1'b1;
				last = dec_q ? (rnd_q == '0) : (rnd_q == RW'(nr));
				if (last) st_d = ST_OUT;
				else rnd_d = dec_q ? rnd_q - 1'b1 : rnd_q + 1'b1;
			end
			ST_OUT: if (out_load) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	acbc_round #(.MAX_ROUNDS(MAX_ROUNDS)) u_rnd (
		.clk, .we(kwe), .waddr(kaddr), .wdata(kdata), .rd_round(rnd_d),
		.load, .step, .last, .dec(dec_q), .din(blk_q), .state(rstate)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			rnd_q    <= '0;
			rvalid_q <= 1'b0;
			chain_q  <= '0;
		end else begin
			st_q  <= st_d;
			rnd_q <= rnd_d;
			if (accept && restart) chain_q <= iv_q;
			if (out_load) begin
				rvalid_q <= 1'b1;
				chain_q  <= dec_q ? blk_q : rstate;
			end else if (rvalid_q && !out_stall) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	assign chain_use = (restart) ? iv_q : chain_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_q <= cmd;
			blk_q <= cmd ? {data_high, data_low} : ({data_high, data_low} ^ chain_use);
		end
		if (out_load) res_q <= dec_q ? (rstate ^ chain_q) : rstate;
	end

	assign out_valid   = rvalid_q;
	assign result_high = res_q[127:64];
	assign result_low  = res_q[63:0];
endmodule
`default_nettype wire

// ===== rtl/acbc_checker.sv =====
// port-level checker for the aes cbc block cipher
`default_nettype none
module acbc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [63:0] result_high,
	input wire logic [63:0] result_low
);
	a_long_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall [*50]) else $error("item finished too fast");
	a_no_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid)) else $error("result too early");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(result_high)
		&& $stable(result_low)) else $error("stalled result changed");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("accepted twice in a row");
endmodule

bind aes_cbc_block_cipher acbc_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.result_high, .result_low
);
`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for the aes cbc block cipher with its own cipher model
`default_nettype none
module tb_top;
	import acbc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 1000000;
	localparam logic [2:0] RegUnknown = 3'd7;
	localparam bit CmdEnc = 1'b0;
	localparam bit CmdDec = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = 1'b0;
	logic restart = 1'b0;
	logic [63:0] data_high = '0;
	logic [63:0] data_low = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] result_high;
	logic [63:0] result_low;

	aes_cbc_block_cipher uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// testbench copy of the registers and the chaining block
	bit [1:0] m_key_size;
	bit [63:0] m_key [4];
	bit [63:0] m_iv_high, m_iv_low;
	bit [127:0] m_chain;
	bit [7:0] fwd_box [256];
	bit [7:0] inv_box [256];
	bit [31:0] sched [60];

	bit [127:0] expected_blocks[$];
	bit idling = 1'b1;
	int errors = 0;
	int cycles = 0;
	int n_enc = 0, n_dec = 0, n_restart = 0, n_checked = 0;
	bit [127:0] last_cipher[$];

	function automatic bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
		bit [7:0] p = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	// s-box from the multiplicative inverse and the affine map
	function automatic void build_boxes();
		bit [7:0] inv, s;
		for (int x = 0; x < 256; x++) begin
			inv = 0;
			for (int y = 1; y < 256; y++)
				if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			fwd_box[x] = s;
			inv_box[s] = 8'(x);
		end
	endfunction

	function automatic bit [31:0] box_word(bit [31:0] w);
		return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
	endfunction

	function automatic int expand_schedule();
		int nk, nr;
		bit [7:0] rc = 8'h01;
		bit [31:0] t;
		nk = (m_key_size == 2'd0) ? 4 : (m_key_size == 2'd1) ? 6 : 8;
		nr = nk + 6;
		for (int i = 0; i < nk; i++)
			sched[i] = i[0] ? m_key[i/2][31:0] : m_key[i/2][63:32];
		for (int i = nk; i < 4 * (nr + 1); i++) begin
			t = sched[i-1];
			if (i % nk == 0) begin
				t = box_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_mul(rc, 8'h02);
			end else if (nk == 8 && i % nk == 4) begin
				t = box_word(t);
			end
			sched[i] = sched[i-nk] ^ t;
		end
		return nr;
	endfunction

	function automatic void add_round(ref bit [7:0] st [16], input int r);
		for (int c = 0; c < 4; c++)
			for (int j = 0; j < 4; j++) st[c*4+j] ^= sched[4*r+c][31-8*j -: 8];
	endfunction

	function automatic void sub_rows(ref bit [7:0] st [16], input bit dec);
		bit [7:0] t [16];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (dec) t[((c+r)%4)*4+r] = inv_box[st[c*4+r]];
				else t[c*4+r] = fwd_box[st[((c+r)%4)*4+r]];
			end
		st = t;
	endfunction

	function automatic void mix_cols(ref bit [7:0] st [16], input bit dec);
		bit [7:0] k0, k1, k2, k3;
		bit [7:0] a [4];
		k0 = dec ? 8'd14 : 8'd2;
		k1 = dec ? 8'd11 : 8'd3;
		k2 = dec ? 8'd13 : 8'd1;
		k3 = dec ? 8'd9 : 8'd1;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) a[i] = st[c*4+i];
			for (int i = 0; i < 4; i++)
				st[c*4+i] = gf_mul(a[i], k0) ^ gf_mul(a[(i+1)%4], k1)
					^ gf_mul(a[(i+2)%4], k2) ^ gf_mul(a[(i+3)%4], k3);
		end
	endfunction

	// one cbc step on the testbench state, returns the output block
	function automatic bit [127:0] cbc_block(bit dec, bit rst, bit [127:0] din);
		bit [7:0] st [16];
		bit [127:0] blk, res;
		int nr;
		if (rst) m_chain = {m_iv_high, m_iv_low};
		nr = expand_schedule();
		blk = dec ? din : din ^ m_chain;
		for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
		if (!dec) begin
			add_round(st, 0);
			for (int r = 1; r < nr; r++) begin
				sub_rows(st, 1'b0);
				mix_cols(st, 1'b0);
				add_round(st, r);
			end
			sub_rows(st, 1'b0);
			add_round(st, nr);
		end else begin
			add_round(st, nr);
			for (int r = nr - 1; r >= 1; r--) begin
				sub_rows(st, 1'b1);
				add_round(st, r);
				mix_cols(st, 1'b1);
			end
			sub_rows(st, 1'b1);
			add_round(st, 0);
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
		if (dec) begin
			res ^= m_chain;
			m_chain = din;
		end else begin
			m_chain = res;
		end
		return res;
	endfunction

	task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			RegKeySize: m_key_size = (val[1:0] == 2'd3) ? 2'd2 : val[1:0];
			RegKey0: m_key[0] = val;
			RegKey1: m_key[1] = val;
			RegKey2: m_key[2] = val;
			RegKey3: m_key[3] = val;
			RegIvHigh: m_iv_high = val;
			RegIvLow: m_iv_low = val;
			default: ;
		endcase
	endtask

	task automatic send_block(bit op, bit rst, bit [127:0] din);
		bit [127:0] res;
		if (idling && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 5)) @(posedge clk);
		@(posedge clk);
		in_valid <= 1'b1;
		cmd <= op;
		restart <= rst;
		data_high <= din[127:64];
		data_low <= din[63:0];
		do @(posedge clk); while (in_stall);
		in_valid <= 1'b0;
		res = cbc_block(op, rst, din);
		expected_blocks.push_back(res);
		if (op == CmdEnc) begin
			n_enc++;
			last_cipher.push_back(res);
			if (last_cipher.size() > 8) void'(last_cipher.pop_front());
		end else begin
			n_dec++;
		end
		if (rst) n_restart++;
	endtask

	task automatic drain();
		while (expected_blocks.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic bit [127:0] rand_block();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic bit [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// result checker
	always @(posedge clk) begin
		bit [127:0] exp_blk;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_blocks.size() == 0) begin
				$error("unexpected result item %h_%h", result_high, result_low);
				errors++;
			end else begin
				exp_blk = expected_blocks.pop_front();
				n_checked++;
				if (result_high !== exp_blk[127:64]) begin
					$error("result_high expected %h actual %h", exp_blk[127:64], result_high);
					errors++;
				end
				if (result_low !== exp_blk[63:0]) begin
					$error("result_low expected %h actual %h", exp_blk[63:0], result_low);
					errors++;
				end
			end
		end
	end

	// receiver stalls in bursts while idling is set
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idling && $urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("** aes_cbc_block_cipher: FAILED **");
			$finish;
		end
	end

	task automatic test_directed();
		// no restart yet: chain starts at zero, reset key of all zeros, 256 bits
		send_block(CmdEnc, 1'b0, '0);
		send_block(CmdEnc, 1'b0, '1);
		send_block(CmdDec, 1'b0, '0);
		send_block(CmdDec, 1'b1, '1);
		drain();
		cfg_write(RegKey0, 64'h0001020304050607);
		cfg_write(RegKey1, 64'h08090a0b0c0d0e0f);
		cfg_write(RegKey2, 64'h1011121314151617);
		cfg_write(RegKey3, 64'h18191a1b1c1d1e1f);
		cfg_write(RegIvHigh, '1);
		cfg_write(RegIvLow, 64'h8000000000000001);
		// unknown register index is ignored
		cfg_write(RegUnknown, '1);
		for (int ks = 0; ks < 4; ks++) begin
			drain();
			// code 3 acts as a 256-bit key
			cfg_write(RegKeySize, {62'h0, ks[1:0]});
			send_block(CmdEnc, 1'b1, 128'h00112233445566778899aabbccddeeff);
			send_block(CmdEnc, 1'b0, '1);
			send_block(CmdDec, 1'b1, last_cipher[$-1]);
			send_block(CmdDec, 1'b0, last_cipher[$]);
		end
		drain();
	endtask

	task automatic test_random_streams(int n_items);
		int sent = 0;
		int len;
		bit op;
		while (sent < n_items) begin
			drain();
			cfg_write(RegKeySize, rand_word());
			if ($urandom_range(0, 1)) cfg_write(RegKey0, rand_word());
			if ($urandom_range(0, 1)) cfg_write(RegKey1, $urandom_range(0, 1) ? '1 : rand_word());
			cfg_write(RegKey2, rand_word());
			cfg_write(RegKey3, $urandom_range(0, 3) == 0 ? '0 : rand_word());
			cfg_write(RegIvHigh, rand_word());
			cfg_write(RegIvLow, rand_word());
			len = $urandom_range(4, 40);
			op = 1'($urandom_range(0, 1));
			for (int i = 0; i < len && sent < n_items; i++) begin
				// mostly one direction per stream, restart at its head, some noise
				if ($urandom_range(0, 9) == 0) begin
					send_block(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_block());
				end else if (op == CmdDec && last_cipher.size() != 0 && $urandom_range(0, 1)) begin
					send_block(CmdDec, i == 0, last_cipher[$urandom_range(0, last_cipher.size() - 1)]);
				end else begin
					send_block(op, i == 0, rand_block());
				end
				sent++;
			end
		end
		drain();
	endtask

	task automatic test_full_rate(int n_items);
		idling = 1'b0;
		for (int i = 0; i < n_items; i++)
			send_block(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0, rand_block());
		drain();
	endtask

	initial begin
		build_boxes();
		m_key_size = 2'd2;
		foreach (m_key[i]) m_key[i] = '0;
		m_iv_high = '0;
		m_iv_low = '0;
		m_chain = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_streams(1450);
		test_full_rate(150);
		$display("checked %0d blocks: %0d encrypt, %0d decrypt, %0d restarts",
			n_checked, n_enc, n_dec, n_restart);
		$display("key sizes 128/192/256 and unused code, random keys, ivs and stalls");
		if (errors == 0 && expected_blocks.size() == 0) begin
			$display("** aes_cbc_block_cipher: PASSED **");
		end else begin
			$display("** aes_cbc_block_cipher: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/acbc_pkg.sv
rtl/acbc_key_exp.sv
rtl/acbc_round.sv
rtl/aes_cbc_block_cipher.sv
rtl/acbc_checker.sv
test/tb_top.sv
